FILE: rtl/srht_pkg.sv
package srht_pkg;

  localparam int FRAC_BITS = 16;
  localparam int T_BITS    = 16;

  localparam int SQ_BITS = 33;
  localparam int SQW     = 67;

  localparam int DIV_NW = 68;
  localparam int DIV_DW = 34;
  localparam int DIV_QW = 34;

  typedef struct packed {
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
  } in_t;

  typedef struct packed {
    logic               hit_flag;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] surf_normal_x;
    logic signed [31:0] surf_normal_y;
    logic [T_BITS:0]    hit_fraction;
  } out_t;

  typedef struct packed {
    logic               hit;
    logic               at_start;
    logic               zlen;
    logic               vert;
    logic               neg_a;
    logic               neg_b;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic [65:0]        num_a;
    logic [32:0]        num_b;
    logic [32:0]        den;
  } ctx_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < 36'shF_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/srht_front.sv
module srht_front
  import srht_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  in_t              in_data,
  output logic             out_valid,
  output ctx_t             out_ctx,
  output logic [SQW-1:0]   out_l2
);

  localparam int EDGE_L = 0;
  localparam int EDGE_T = 1;
  localparam int EDGE_R = 2;
  localparam int EDGE_B = 3;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] mnx;
    logic signed [31:0] mny;
    logic signed [31:0] mxx;
    logic signed [31:0] mxy;
    logic signed [32:0] rx;
    logic signed [32:0] ry;
    logic signed [32:0] bxl;
    logic signed [32:0] bxr;
    logic signed [32:0] byb;
    logic signed [32:0] byt;
    logic signed [32:0] w;
    logic signed [32:0] h;
    logic               ins;
  } geom_t;

  function automatic logic t_ok(input logic signed [32:0] b, input logic signed [32:0] r,
                                input logic spos, input logic sneg);
    logic ok;
    if (spos) begin
      ok = (b >= 33'sd0) && (b <= r);
    end else if (sneg) begin
      ok = (b <= 33'sd0) && (b >= r);
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  geom_t g1_r, g2_r, g3_r;

  logic signed [65:0] p_lr2_r, p_rr2_r, p_bx2_r, p_tx2_r, p_dv2_r, p_dh2_r, p_xx2_r, p_yy2_r;
  logic [3:0] tok2_r, tok3_r;

  logic signed [66:0] un3_r [4];
  logic signed [66:0] dn3_r [4];
  logic [SQW-1:0] l2_3_r, l2_4_r, l2_5_r;

  logic [3:0] hit_e;
  ctx_t ctx4_nxt, ctx4_r, ctx5_nxt, ctx5_r;
  logic [32:0] ro4_nxt, ro4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    g1_r.sx  <= in_data.seg_start_x;
    g1_r.sy  <= in_data.seg_start_y;
    g1_r.mnx <= in_data.box_min_x;
    g1_r.mny <= in_data.box_min_y;
    g1_r.mxx <= in_data.box_max_x;
    g1_r.mxy <= in_data.box_max_y;
    g1_r.rx  <= 33'(in_data.seg_end_x) - 33'(in_data.seg_start_x);
    g1_r.ry  <= 33'(in_data.seg_end_y) - 33'(in_data.seg_start_y);
    g1_r.bxl <= 33'(in_data.box_min_x) - 33'(in_data.seg_start_x);
    g1_r.bxr <= 33'(in_data.box_max_x) - 33'(in_data.seg_start_x);
    g1_r.byb <= 33'(in_data.box_min_y) - 33'(in_data.seg_start_y);
    g1_r.byt <= 33'(in_data.box_max_y) - 33'(in_data.seg_start_y);
    g1_r.w   <= 33'(in_data.box_max_x) - 33'(in_data.box_min_x);
    g1_r.h   <= 33'(in_data.box_max_y) - 33'(in_data.box_min_y);
    g1_r.ins <= (in_data.seg_start_x >= in_data.box_min_x) &&
                (in_data.seg_start_y >= in_data.box_min_y) &&
                (in_data.seg_start_x <= in_data.box_max_x) &&
                (in_data.seg_start_y <= in_data.box_max_y);
  end

  always_ff @(posedge clk) begin
    g2_r    <= g1_r;
    p_lr2_r <= 66'(g1_r.bxl) * 66'(g1_r.ry);
    p_rr2_r <= 66'(g1_r.bxr) * 66'(g1_r.ry);
    p_bx2_r <= 66'(g1_r.byb) * 66'(g1_r.rx);
    p_tx2_r <= 66'(g1_r.byt) * 66'(g1_r.rx);
    p_dv2_r <= 66'(g1_r.rx) * 66'(g1_r.h);
    p_dh2_r <= 66'(g1_r.ry) * 66'(g1_r.w);
    p_xx2_r <= 66'(g1_r.rx) * 66'(g1_r.rx);
    p_yy2_r <= 66'(g1_r.ry) * 66'(g1_r.ry);
    tok2_r[EDGE_L] <= t_ok(g1_r.bxl, g1_r.rx, g1_r.h > 33'sd0, g1_r.h < 33'sd0);
    tok2_r[EDGE_T] <= t_ok(g1_r.byt, g1_r.ry, g1_r.w < 33'sd0, g1_r.w > 33'sd0);
    tok2_r[EDGE_R] <= t_ok(g1_r.bxr, g1_r.rx, g1_r.h < 33'sd0, g1_r.h > 33'sd0);
    tok2_r[EDGE_B] <= t_ok(g1_r.byb, g1_r.ry, g1_r.w > 33'sd0, g1_r.w < 33'sd0);
  end

  always_ff @(posedge clk) begin
    g3_r   <= g2_r;
    tok3_r <= tok2_r;
    un3_r[EDGE_L] <= 67'(p_lr2_r) - 67'(p_bx2_r);
    un3_r[EDGE_T] <= 67'(p_lr2_r) - 67'(p_tx2_r);
    un3_r[EDGE_R] <= 67'(p_rr2_r) - 67'(p_tx2_r);
    un3_r[EDGE_B] <= 67'(p_rr2_r) - 67'(p_bx2_r);
    dn3_r[EDGE_L] <= 67'(p_dv2_r);
    dn3_r[EDGE_T] <= -67'(p_dh2_r);
    dn3_r[EDGE_R] <= -67'(p_dv2_r);
    dn3_r[EDGE_B] <= 67'(p_dh2_r);
    l2_3_r <= SQW'($unsigned(p_xx2_r)) + SQW'($unsigned(p_yy2_r));
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hit_e[k] = tok3_r[k] && (dn3_r[k] > 67'sd0) && (un3_r[k] >= 67'sd0) &&
                 (un3_r[k] <= dn3_r[k]);
    end
  end

  always_comb begin
    ctx4_nxt = '0;
    ro4_nxt  = '0;
    if (g3_r.ins) begin
      ctx4_nxt.hit      = 1'b1;
      ctx4_nxt.at_start = 1'b1;
      ctx4_nxt.base_x   = g3_r.sx;
      ctx4_nxt.base_y   = g3_r.sy;
      ctx4_nxt.neg_a    = g3_r.rx > 33'sd0;
      ctx4_nxt.neg_b    = g3_r.ry > 33'sd0;
      ctx4_nxt.num_a    = 66'(abs33(g3_r.rx));
      ctx4_nxt.num_b    = abs33(g3_r.ry);
    end else if (hit_e[EDGE_L]) begin
      ctx4_nxt.hit    = 1'b1;
      ctx4_nxt.vert   = 1'b1;
      ctx4_nxt.base_x = g3_r.mnx;
      ctx4_nxt.base_y = g3_r.sy;
      ctx4_nxt.nrm_x  = sat32(-36'(g3_r.h));
      ctx4_nxt.num_b  = abs33(g3_r.bxl);
      ctx4_nxt.den    = abs33(g3_r.rx);
      ctx4_nxt.neg_a  = g3_r.ry < 33'sd0;
      ro4_nxt         = abs33(g3_r.ry);
    end else if (hit_e[EDGE_T]) begin
      ctx4_nxt.hit    = 1'b1;
      ctx4_nxt.base_x = g3_r.sx;
      ctx4_nxt.base_y = g3_r.mxy;
      ctx4_nxt.nrm_y  = sat32(36'(g3_r.w));
      ctx4_nxt.num_b  = abs33(g3_r.byt);
      ctx4_nxt.den    = abs33(g3_r.ry);
      ctx4_nxt.neg_a  = g3_r.rx < 33'sd0;
      ro4_nxt         = abs33(g3_r.rx);
    end else if (hit_e[EDGE_R]) begin
      ctx4_nxt.hit    = 1'b1;
      ctx4_nxt.vert   = 1'b1;
      ctx4_nxt.base_x = g3_r.mxx;
      ctx4_nxt.base_y = g3_r.sy;
      ctx4_nxt.nrm_x  = sat32(36'(g3_r.h));
      ctx4_nxt.num_b  = abs33(g3_r.bxr);
      ctx4_nxt.den    = abs33(g3_r.rx);
      ctx4_nxt.neg_a  = g3_r.ry < 33'sd0;
      ro4_nxt         = abs33(g3_r.ry);
    end else if (hit_e[EDGE_B]) begin
      ctx4_nxt.hit    = 1'b1;
      ctx4_nxt.base_x = g3_r.sx;
      ctx4_nxt.base_y = g3_r.mny;
      ctx4_nxt.nrm_y  = sat32(-36'(g3_r.w));
      ctx4_nxt.num_b  = abs33(g3_r.byb);
      ctx4_nxt.den    = abs33(g3_r.ry);
      ctx4_nxt.neg_a  = g3_r.rx < 33'sd0;
      ro4_nxt         = abs33(g3_r.rx);
    end
  end

  always_ff @(posedge clk) begin
    ctx4_r <= ctx4_nxt;
    ro4_r  <= ro4_nxt;
    l2_4_r <= l2_3_r;
  end

  always_comb begin
    ctx5_nxt = ctx4_r;
    if (!ctx4_r.at_start) begin
      ctx5_nxt.num_a = 66'(ctx4_r.num_b) * 66'(ro4_r);
    end
  end

  always_ff @(posedge clk) begin
    ctx5_r <= ctx5_nxt;
    l2_5_r <= l2_4_r;
  end

  assign out_valid = v5_r;
  assign out_ctx   = ctx5_r;
  assign out_l2    = l2_5_r;

endmodule

FILE: rtl/srht_isqrt.sv
module srht_isqrt
  import srht_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  ctx_t               in_ctx,
  input  logic [SQW-1:0]     in_l2,
  output logic               out_valid,
  output ctx_t               out_ctx,
  output logic [SQ_BITS-1:0] out_root
);

  logic [SQ_BITS-1:0] vld_r;
  logic [SQW-1:0]     rem_i [SQ_BITS];
  logic [SQW-1:0]     rem_nxt [SQ_BITS];
  logic [SQW-1:0]     rem_r [SQ_BITS];
  logic [SQ_BITS-1:0] root_i [SQ_BITS];
  logic [SQ_BITS-1:0] root_nxt [SQ_BITS];
  logic [SQ_BITS-1:0] root_r [SQ_BITS];
  ctx_t               ctx_i [SQ_BITS];
  ctx_t               ctx_r [SQ_BITS];

  always_comb begin
    rem_i[0]  = in_l2;
    root_i[0] = '0;
    ctx_i[0]  = in_ctx;
    for (int k = 1; k < SQ_BITS; k++) begin
      rem_i[k]  = rem_r[k-1];
      root_i[k] = root_r[k-1];
      ctx_i[k]  = ctx_r[k-1];
    end
  end

  always_comb begin
    logic [SQW-1:0] trial;
    for (int k = 0; k < SQ_BITS; k++) begin
      trial = (SQW'(root_i[k]) << (SQ_BITS - k)) | (SQW'(1) << (2 * (SQ_BITS - 1 - k)));
      if (rem_i[k] >= trial) begin
        rem_nxt[k]  = rem_i[k] - trial;
        root_nxt[k] = root_i[k] | (SQ_BITS'(1) << (SQ_BITS - 1 - k));
      end else begin
        rem_nxt[k]  = rem_i[k];
        root_nxt[k] = root_i[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SQ_BITS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    ctx_r  <= ctx_i;
  end

  assign out_valid = vld_r[SQ_BITS-1];
  assign out_ctx   = ctx_r[SQ_BITS-1];
  assign out_root  = root_r[SQ_BITS-1];

endmodule

FILE: rtl/srht_div.sv
module srht_div
  import srht_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  ctx_t               in_ctx,
  input  logic [SQ_BITS-1:0] in_root,
  output logic               out_valid,
  output ctx_t               out_ctx,
  output logic [DIV_QW-1:0]  out_qa,
  output logic [DIV_QW-1:0]  out_qb
);

  logic              op_v_r;
  ctx_t              op_ctx_nxt;
  ctx_t              op_ctx_r;
  logic [DIV_NW-1:0] na_r, nb_r;
  logic [DIV_DW-1:0] da_r, db_r;

  logic [DIV_QW-1:0] vld_r;
  logic [DIV_NW-1:0] ra_i [DIV_QW];
  logic [DIV_NW-1:0] rb_i [DIV_QW];
  logic [DIV_NW-1:0] ra_nxt [DIV_QW];
  logic [DIV_NW-1:0] rb_nxt [DIV_QW];
  logic [DIV_NW-1:0] ra_r [DIV_QW];
  logic [DIV_NW-1:0] rb_r [DIV_QW];
  logic [DIV_DW-1:0] da_i [DIV_QW];
  logic [DIV_DW-1:0] db_i [DIV_QW];
  logic [DIV_DW-1:0] da_r2 [DIV_QW];
  logic [DIV_DW-1:0] db_r2 [DIV_QW];
  logic [DIV_QW-1:0] qa_i [DIV_QW];
  logic [DIV_QW-1:0] qb_i [DIV_QW];
  logic [DIV_QW-1:0] qa_nxt [DIV_QW];
  logic [DIV_QW-1:0] qb_nxt [DIV_QW];
  logic [DIV_QW-1:0] qa_r [DIV_QW];
  logic [DIV_QW-1:0] qb_r [DIV_QW];
  ctx_t              ctx_i [DIV_QW];
  ctx_t              ctx_r [DIV_QW];

  always_comb begin
    op_ctx_nxt      = in_ctx;
    op_ctx_nxt.zlen = in_ctx.at_start ? (in_root == '0) : 1'b0;
  end

  always_ff @(posedge clk) begin
    op_ctx_r <= op_ctx_nxt;
    if (in_ctx.at_start) begin
      na_r <= (DIV_NW'(in_ctx.num_a[32:0]) << (FRAC_BITS + 1)) + DIV_NW'(in_root);
      nb_r <= (DIV_NW'(in_ctx.num_b) << (FRAC_BITS + 1)) + DIV_NW'(in_root);
      da_r <= {in_root, 1'b0};
      db_r <= {in_root, 1'b0};
    end else begin
      na_r <= DIV_NW'({in_ctx.num_a, 1'b0}) + DIV_NW'(in_ctx.den);
      nb_r <= (DIV_NW'(in_ctx.num_b) << (T_BITS + 1)) + DIV_NW'(in_ctx.den);
      da_r <= {in_ctx.den, 1'b0};
      db_r <= {in_ctx.den, 1'b0};
    end
  end

  always_comb begin
    ra_i[0]  = na_r;
    rb_i[0]  = nb_r;
    da_i[0]  = da_r;
    db_i[0]  = db_r;
    qa_i[0]  = '0;
    qb_i[0]  = '0;
    ctx_i[0] = op_ctx_r;
    for (int k = 1; k < DIV_QW; k++) begin
      ra_i[k]  = ra_r[k-1];
      rb_i[k]  = rb_r[k-1];
      da_i[k]  = da_r2[k-1];
      db_i[k]  = db_r2[k-1];
      qa_i[k]  = qa_r[k-1];
      qb_i[k]  = qb_r[k-1];
      ctx_i[k] = ctx_r[k-1];
    end
  end

  always_comb begin
    logic [DIV_NW-1:0] sha;
    logic [DIV_NW-1:0] shb;
    for (int k = 0; k < DIV_QW; k++) begin
      sha = DIV_NW'(da_i[k]) << (DIV_QW - 1 - k);
      shb = DIV_NW'(db_i[k]) << (DIV_QW - 1 - k);
      if (ra_i[k] >= sha) begin
        ra_nxt[k] = ra_i[k] - sha;
        qa_nxt[k] = qa_i[k] | (DIV_QW'(1) << (DIV_QW - 1 - k));
      end else begin
        ra_nxt[k] = ra_i[k];
        qa_nxt[k] = qa_i[k];
      end
      if (rb_i[k] >= shb) begin
        rb_nxt[k] = rb_i[k] - shb;
        qb_nxt[k] = qb_i[k] | (DIV_QW'(1) << (DIV_QW - 1 - k));
      end else begin
        rb_nxt[k] = rb_i[k];
        qb_nxt[k] = qb_i[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_v_r <= 1'b0;
      vld_r  <= '0;
    end else begin
      op_v_r <= in_valid;
      vld_r  <= {vld_r[DIV_QW-2:0], op_v_r};
    end
  end

  always_ff @(posedge clk) begin
    ra_r  <= ra_nxt;
    rb_r  <= rb_nxt;
    da_r2 <= da_i;
    db_r2 <= db_i;
    qa_r  <= qa_nxt;
    qb_r  <= qb_nxt;
    ctx_r <= ctx_i;
  end

  assign out_valid = vld_r[DIV_QW-1];
  assign out_ctx   = ctx_r[DIV_QW-1];
  assign out_qa    = qa_r[DIV_QW-1];
  assign out_qb    = qb_r[DIV_QW-1];

endmodule

FILE: rtl/segment_rect_hit_test_top.sv
// Hit test of a 2D segment against an axis-aligned rectangle in signed fixed point.
// A transaction is offered on in_data with start high; it is taken at every clock
// edge where start is high, and busy is always low, so one transaction can enter
// in every cycle.
// Each transaction produces exactly one result on out_data, marked by out_valid
// for a single cycle. The depth comes from a five stage front end (differences,
// products, edge tests, edge selection, hit point product), a 33 stage square root
// that works one root bit per stage, one operand stage and a 34 stage divider pair
// that works one quotient bit per stage, and the output register. Results leave in
// the order the transactions came in.
// Throughput is one transaction per cycle.
// The receiver cannot stall the block; every result must be taken in the cycle
// it is shown.
// Synchronous reset clears all valid bits in flight, so no result appears for a
// transaction taken before reset.
module segment_rect_hit_test_top
  import srht_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  logic               f_valid;
  ctx_t               f_ctx;
  logic [SQW-1:0]     f_l2;
  logic               s_valid;
  ctx_t               s_ctx;
  logic [SQ_BITS-1:0] s_root;
  logic               d_valid;
  ctx_t               d_ctx;
  logic [DIV_QW-1:0]  d_qa;
  logic [DIV_QW-1:0]  d_qb;

  logic signed [35:0] sqa;
  logic signed [35:0] sqb;
  out_t               res_nxt;
  logic               out_valid_r;
  out_t               out_data_r;

  assign busy = 1'b0;

  srht_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_ctx   (f_ctx),
    .out_l2    (f_l2)
  );

  srht_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ctx    (f_ctx),
    .in_l2     (f_l2),
    .out_valid (s_valid),
    .out_ctx   (s_ctx),
    .out_root  (s_root)
  );

  srht_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ctx    (s_ctx),
    .in_root   (s_root),
    .out_valid (d_valid),
    .out_ctx   (d_ctx),
    .out_qa    (d_qa),
    .out_qb    (d_qb)
  );

  always_comb begin
    sqa = d_ctx.neg_a ? -$signed(36'(d_qa)) : $signed(36'(d_qa));
    sqb = d_ctx.neg_b ? -$signed(36'(d_qb)) : $signed(36'(d_qb));
    res_nxt = '0;
    if (d_ctx.hit) begin
      res_nxt.hit_flag = 1'b1;
      if (d_ctx.at_start) begin
        res_nxt.hit_x = d_ctx.base_x;
        res_nxt.hit_y = d_ctx.base_y;
        if (!d_ctx.zlen) begin
          res_nxt.surf_normal_x = sat32(sqa);
          res_nxt.surf_normal_y = sat32(sqb);
        end
      end else begin
        if (d_ctx.vert) begin
          res_nxt.hit_x = d_ctx.base_x;
          res_nxt.hit_y = sat32(36'(d_ctx.base_y) + sqa);
        end else begin
          res_nxt.hit_x = sat32(36'(d_ctx.base_x) + sqa);
          res_nxt.hit_y = d_ctx.base_y;
        end
        res_nxt.surf_normal_x = d_ctx.nrm_x;
        res_nxt.surf_normal_y = d_ctx.nrm_y;
        res_nxt.hit_fraction  = d_qb[T_BITS:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
